@@ rtl/lru_writeback_tag_cache_defines.svh @@
`ifndef LRU_WRITEBACK_TAG_CACHE_DEFINES_SVH
`define LRU_WRITEBACK_TAG_CACHE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define LTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ltc_pkg.sv @@
package ltc_pkg;

	localparam int N  = 16;
	localparam int SW = 4;
	localparam int TW = 32;
	localparam int OW = 5;

	localparam logic [1:0] F_GET    = 2'd0;
	localparam logic [1:0] F_SET    = 2'd1;
	localparam logic [1:0] F_REMOVE = 2'd2;
	localparam logic [1:0] F_FLUSH  = 2'd3;

	localparam logic [2:0] K_HIT       = 3'd0;
	localparam logic [2:0] K_LOAD      = 3'd1;
	localparam logic [2:0] K_WRITEBACK = 3'd2;
	localparam logic [2:0] K_DIRECT    = 3'd3;
	localparam logic [2:0] K_EMPTY     = 3'd4;
	localparam logic [2:0] K_DONE      = 3'd5;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TOUCH,
		OP_INSERT,
		OP_DROP,
		OP_SET_DIRTY,
		OP_CLEAR_DIRTY
	} store_op_t;

	typedef struct packed {
		store_op_t       op;
		logic [SW-1:0]   slot;
		logic [TW-1:0]   tag;
		logic            dv;
	} store_cmd_t;

	typedef struct packed {
		logic            hit;
		logic [SW-1:0]   hit_slot;
		logic            hit_dirty;
		logic            free_found;
		logic [SW-1:0]   free_slot;
		logic            rank_found;
		logic [SW-1:0]   rank_slot;
		logic            rank_dirty;
		logic [TW-1:0]   rank_tag;
	} store_view_t;

endpackage

@@ rtl/ltc_store.sv @@
module ltc_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [ltc_pkg::TW-1:0] q_tag,
	input  logic [ltc_pkg::SW-1:0] q_rank,
	input  ltc_pkg::store_cmd_t    cmd,
	output ltc_pkg::store_view_t   view
);
	import ltc_pkg::*;

	logic [TW-1:0] tag_q   [N];
	logic [SW-1:0] rank_q  [N];
	logic [N-1:0]  valid_q;
	logic [N-1:0]  dirty_q;

	always_comb begin
		view = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == q_tag) begin
				view.hit      = 1'b1;
				view.hit_slot = SW'(i);
			end
			if (!valid_q[i]) begin
				view.free_found = 1'b1;
				view.free_slot  = SW'(i);
			end
			if (valid_q[i] && rank_q[i] == q_rank) begin
				view.rank_found = 1'b1;
				view.rank_slot  = SW'(i);
			end
		end
		view.hit_dirty  = dirty_q[view.hit_slot];
		view.rank_dirty = dirty_q[view.rank_slot];
		view.rank_tag   = tag_q[view.rank_slot];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_TOUCH: begin
				for (int i = 0; i < N; i++)
					if (valid_q[i] && rank_q[i] < rank_q[cmd.slot])
						rank_q[i] <= rank_q[i] + 1'b1;
				rank_q[cmd.slot] <= '0;
			end
			OP_INSERT: begin
				for (int i = 0; i < N; i++)
					if (valid_q[i] && SW'(i) != cmd.slot)
						rank_q[i] <= rank_q[i] + 1'b1;
				rank_q[cmd.slot] <= '0;
				tag_q[cmd.slot]  <= cmd.tag;
			end
			OP_DROP: begin
				for (int i = 0; i < N; i++)
					if (valid_q[i] && rank_q[i] > rank_q[cmd.slot])
						rank_q[i] <= rank_q[i] - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
		end else begin
			case (cmd.op)
				OP_INSERT: begin
					valid_q[cmd.slot] <= 1'b1;
					dirty_q[cmd.slot] <= 1'b0;
				end
				OP_DROP: begin
					valid_q[cmd.slot] <= 1'b0;
					dirty_q[cmd.slot] <= 1'b0;
				end
				OP_SET_DIRTY:   dirty_q[cmd.slot] <= cmd.dv;
				OP_CLEAR_DIRTY: dirty_q[cmd.slot] <= 1'b0;
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/lru_writeback_tag_cache.sv @@
// channel   | direction | handshake                 | payload
// item      | in        | start && !busy            | func, inode_number, dirty_value
// result    | out       | result_strobe (one cycle) | kind, result_inode, slot, last
// config    | in        | cfg_valid && cfg_ready    | cfg_data (capacity)
//
// Get, set and remove run lookup, then evict, write-back or empty as needed, then
// done; flush walks the cached entries in the directory, one recency rank a cycle.
// Reset clears all valid and dirty marks and occupancy, and sets capacity to 16.
// One result leaves per cycle at most; the receiver takes every beat as shown.
// cfg_ready is always high.
`include "lru_writeback_tag_cache_defines.svh"

module lru_writeback_tag_cache (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             func,
	input  logic [ltc_pkg::TW-1:0] inode_number,
	input  logic                   dirty_value,
	output logic                   result_strobe,
	output logic [2:0]             kind,
	output logic [ltc_pkg::TW-1:0] result_inode,
	output logic [ltc_pkg::SW-1:0] slot,
	output logic                   last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [ltc_pkg::OW-1:0] cfg_data
);
	import ltc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_EVICT = 3'd2;
	localparam logic [2:0] ST_WB    = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [1:0]    func_q;
	logic [TW-1:0] ino_q;
	logic          dv_q;
	logic [OW-1:0] occ_q, occ_d;
	logic [OW-1:0] cap_q;
	logic [OW-1:0] cnt_q, cnt_d;
	logic [TW-1:0] wb_tag_q, wb_tag_d;
	logic [SW-1:0] wb_slot_q, wb_slot_d;
	logic          wb_pend_q, wb_pend_d;
	logic [SW-1:0] emp_slot_q, emp_slot_d;
	logic [OW-1:0] cap_eff;
	logic [OW-1:0] q_rank_w;

	logic          e_valid;
	logic [2:0]    e_kind;
	logic [TW-1:0] e_ino;
	logic [SW-1:0] e_slot;
	logic          e_last;

	store_cmd_t    cmd;
	store_view_t   view;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign cap_eff   = (cap_q > OW'(N)) ? OW'(N) : cap_q;
	assign q_rank_w  = (state_q == ST_FLUSH) ? cnt_q - 1'b1 : occ_q - 1'b1;

	ltc_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.q_tag  (ino_q),
		.q_rank (q_rank_w[SW-1:0]),
		.cmd    (cmd),
		.view   (view)
	);

	always_comb begin
		state_d    = state_q;
		occ_d      = occ_q;
		cnt_d      = cnt_q;
		wb_tag_d   = wb_tag_q;
		wb_slot_d  = wb_slot_q;
		wb_pend_d  = wb_pend_q;
		emp_slot_d = emp_slot_q;
		cmd        = '{op: OP_NOP, slot: '0, tag: ino_q, dv: dv_q};
		e_valid    = 1'b0;
		e_kind     = K_DONE;
		e_ino      = ino_q;
		e_slot     = '0;
		e_last     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = ST_DONE;
				case (func_q)
					F_GET: begin
						e_valid = 1'b1;
						if (view.hit) begin
							e_kind   = K_HIT;
							e_slot   = view.hit_slot;
							cmd.op   = OP_TOUCH;
							cmd.slot = view.hit_slot;
						end else if (view.free_found) begin
							e_kind   = K_LOAD;
							e_slot   = view.free_slot;
							cmd.op   = OP_INSERT;
							cmd.slot = view.free_slot;
							occ_d    = occ_q + 1'b1;
							if (occ_q + 1'b1 > cap_eff)
								state_d = ST_EVICT;
						end else begin
							e_kind    = K_LOAD;
							e_slot    = view.rank_slot;
							cmd.op    = OP_INSERT;
							cmd.slot  = view.rank_slot;
							wb_pend_d = view.rank_found && view.rank_dirty;
							wb_tag_d  = view.rank_tag;
							wb_slot_d = view.rank_slot;
							if (view.rank_found && view.rank_dirty)
								state_d = ST_WB;
						end
					end
					F_SET: begin
						if (view.hit) begin
							cmd.op   = OP_SET_DIRTY;
							cmd.slot = view.hit_slot;
						end else begin
							e_valid = 1'b1;
							e_kind  = K_DIRECT;
						end
					end
					F_REMOVE: begin
						state_d    = ST_EMPTY;
						emp_slot_d = '0;
						if (view.hit) begin
							emp_slot_d = view.hit_slot;
							cmd.op     = OP_DROP;
							cmd.slot   = view.hit_slot;
							occ_d      = occ_q - 1'b1;
							if (view.hit_dirty) begin
								e_valid = 1'b1;
								e_kind  = K_WRITEBACK;
								e_slot  = view.hit_slot;
							end
						end
					end
					default: begin
						cnt_d = occ_q;
						if (occ_q != '0)
							state_d = ST_FLUSH;
					end
				endcase
			end
			ST_EVICT: begin
				state_d = ST_DONE;
				if (view.rank_found) begin
					cmd.op   = OP_DROP;
					cmd.slot = view.rank_slot;
					occ_d    = occ_q - 1'b1;
					if (view.rank_dirty) begin
						e_valid = 1'b1;
						e_kind  = K_WRITEBACK;
						e_ino   = view.rank_tag;
						e_slot  = view.rank_slot;
					end
				end
			end
			ST_WB: begin
				state_d = ST_DONE;
				e_valid = wb_pend_q;
				e_kind  = K_WRITEBACK;
				e_ino   = wb_tag_q;
				e_slot  = wb_slot_q;
			end
			ST_EMPTY: begin
				state_d = ST_DONE;
				e_valid = 1'b1;
				e_kind  = K_EMPTY;
				e_slot  = emp_slot_q;
			end
			ST_FLUSH: begin
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == OW'(1))
					state_d = ST_DONE;
				if (view.rank_found && view.rank_dirty) begin
					cmd.op   = OP_CLEAR_DIRTY;
					cmd.slot = view.rank_slot;
					e_valid  = 1'b1;
					e_kind   = K_WRITEBACK;
					e_ino    = view.rank_tag;
					e_slot   = view.rank_slot;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
				e_valid = 1'b1;
				e_kind  = K_DONE;
				e_ino   = (func_q == F_FLUSH) ? '0 : ino_q;
				e_last  = 1'b1;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			occ_q         <= '0;
			cap_q         <= OW'(N);
			cnt_q         <= '0;
			wb_pend_q     <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			state_q       <= state_d;
			occ_q         <= occ_d;
			cnt_q         <= cnt_d;
			wb_pend_q     <= wb_pend_d;
			result_strobe <= e_valid;
			if (cfg_valid && cfg_ready)
				cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_q <= func;
			ino_q  <= inode_number;
			dv_q   <= dirty_value;
		end
		wb_tag_q     <= wb_tag_d;
		wb_slot_q    <= wb_slot_d;
		emp_slot_q   <= emp_slot_d;
		kind         <= e_kind;
		result_inode <= e_ino;
		slot         <= e_slot;
		last         <= e_last;
	end

	`LTC_ASSERT_NOW(a_last_ends_item, result_strobe && last, !busy, "done beat while busy")
	`LTC_ASSERT_NOW(a_beat_inside_item, result_strobe && !last, busy, "stray result beat")
	`LTC_ASSERT_NEXT(a_start_takes, start && !busy, busy, "accepted item not started")
	`LTC_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OW'(N), "occupancy above entry count")

endmodule
